>>> hdl/kwm_pkg.sv
// Shared types and constants of the k-way merge engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package kwm_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned NCNT_W  = 7;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_POPPED  = 2'd1;
  localparam logic [ST_W-1:0] ST_DROPPED = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

  typedef struct packed {
    logic capture;
    logic load_exec;
    logic clear_exec;
    logic bad_exec;
    logic scan_step;
    logic scan_cmp;
    logic pop_commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            scan_last;
  } sts_t;

endpackage

>>> hdl/kwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module kwm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/kwm_ctrl.sv
// Sequencing state machine of the k-way merge engine.
// Depends on kwm_pkg; drives commands into kwm_dp and owns both handshakes.
module kwm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  kwm_pkg::sts_t sts_i,
  output kwm_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FLUSH  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts_i.op)
          kwm_pkg::OP_LOAD: begin
            cmd_o.load_exec = 1'b1;
            state_d         = S_DONE;
          end
          kwm_pkg::OP_POP: begin
            state_d = S_SCAN;
          end
          kwm_pkg::OP_CLEAR: begin
            cmd_o.clear_exec = 1'b1;
            state_d          = S_DONE;
          end
          default: begin
            cmd_o.bad_exec = 1'b1;
            state_d        = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.scan_cmp  = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd_o.scan_cmp = 1'b1;
        state_d        = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.pop_commit = 1'b1;
        state_d          = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/kwm_dp.sv
// Datapath of the k-way merge engine: list counters, list memory, head scan
// and result registers. Depends on kwm_pkg and kwm_ram; commanded by kwm_ctrl.
module kwm_dp #(
  parameter int unsigned MAX_LISTS  = 8,
  parameter int unsigned LIST_DEPTH = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [kwm_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  logic [kwm_pkg::OP_W-1:0]             opcode_i,
  input  logic [kwm_pkg::IDX_W-1:0]            list_index_i,
  input  logic signed [kwm_pkg::VAL_W-1:0]     value_i,
  input  kwm_pkg::cmd_t                        cmd_i,
  output kwm_pkg::sts_t                        sts_o,
  output logic [kwm_pkg::ST_W-1:0]             status_o,
  output logic signed [kwm_pkg::VAL_W-1:0]     merged_value_o,
  output logic [kwm_pkg::IDX_W-1:0]            source_list_o
);

  localparam int unsigned LW    = $clog2(MAX_LISTS);
  localparam int unsigned AW    = $clog2(LIST_DEPTH);
  localparam int unsigned CW    = $clog2(LIST_DEPTH + 1);
  localparam int unsigned DEPTH = MAX_LISTS << AW;
  localparam int unsigned RAW   = $clog2(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(LIST_DEPTH);
  localparam logic [kwm_pkg::NCNT_W-1:0] MaxN = kwm_pkg::NCNT_W'(MAX_LISTS);

  logic [kwm_pkg::CFG_W-1:0]        cfg_q;
  logic [kwm_pkg::OP_W-1:0]         op_q;
  logic [kwm_pkg::IDX_W-1:0]        idx_q;
  logic signed [kwm_pkg::VAL_W-1:0] val_q;
  logic [CW-1:0]                    fill_q [MAX_LISTS];
  logic [CW-1:0]                    head_q [MAX_LISTS];
  logic [LW:0]                      scan_j_q;
  logic [LW-1:0]                    cand_q;
  logic                             elig_q;
  logic                             found_q;
  logic [LW-1:0]                    best_q;
  logic signed [kwm_pkg::VAL_W-1:0] bestv_q;
  logic [kwm_pkg::ST_W-1:0]         res_st_q;
  logic signed [kwm_pkg::VAL_W-1:0] res_val_q;
  logic [kwm_pkg::IDX_W-1:0]        res_src_q;

  logic [kwm_pkg::NCNT_W-1:0] n_raw, n_act;
  logic [7:0]                 idx_ext, best_ext;
  logic [LW-1:0]              lst, sel;
  logic [CW-1:0]              rd_fill, rd_head;
  logic                       load_ok;
  logic                       ram_we;
  logic [RAW-1:0]             ram_waddr, ram_raddr;
  logic [kwm_pkg::VAL_W-1:0]  ram_rdata;
  logic                       take;

  always_comb begin
    n_raw = (cfg_q == '0) ? kwm_pkg::NCNT_W'(1) : kwm_pkg::NCNT_W'(cfg_q);
    n_act = (n_raw > MaxN) ? MaxN : n_raw;
  end

  assign idx_ext  = 8'(idx_q);
  assign best_ext = 8'(best_q);
  assign lst      = idx_ext[LW-1:0];

  always_comb begin
    if (cmd_i.scan_step) begin
      sel = scan_j_q[LW-1:0];
    end else if (cmd_i.pop_commit) begin
      sel = best_q;
    end else begin
      sel = lst;
    end
  end

  assign rd_fill = fill_q[sel];
  assign rd_head = head_q[sel];
  assign load_ok = (kwm_pkg::NCNT_W'(idx_q) < n_act) && (rd_fill < DepthC);

  assign ram_we    = cmd_i.load_exec && load_ok;
  assign ram_waddr = RAW'({lst, rd_fill[AW-1:0]});
  assign ram_raddr = RAW'({scan_j_q[LW-1:0], rd_head[AW-1:0]});

  kwm_ram #(
    .WIDTH (kwm_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (val_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign take = cmd_i.scan_cmp && elig_q &&
                (!found_q || ($signed(ram_rdata) < bestv_q));

  assign sts_o.op        = op_q;
  assign sts_o.scan_last = (kwm_pkg::NCNT_W'(scan_j_q) == (n_act - kwm_pkg::NCNT_W'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= kwm_pkg::ACTIVE_RESET;
      for (int i = 0; i < MAX_LISTS; i++) begin
        fill_q[i] <= '0;
        head_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.clear_exec) begin
        for (int i = 0; i < MAX_LISTS; i++) begin
          fill_q[i] <= '0;
          head_q[i] <= '0;
        end
      end
      if (ram_we) begin
        fill_q[sel] <= CW'(rd_fill + 1'b1);
      end
      if (cmd_i.pop_commit && found_q) begin
        head_q[sel] <= CW'(rd_head + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= opcode_i;
      idx_q    <= list_index_i;
      val_q    <= value_i;
      scan_j_q <= '0;
      elig_q   <= 1'b0;
      found_q  <= 1'b0;
    end
    if (cmd_i.scan_step) begin
      scan_j_q <= (LW + 1)'(scan_j_q + 1'b1);
      cand_q   <= scan_j_q[LW-1:0];
      elig_q   <= (rd_head < rd_fill);
    end
    if (take) begin
      found_q <= 1'b1;
      best_q  <= cand_q;
      bestv_q <= $signed(ram_rdata);
    end
    if (cmd_i.load_exec) begin
      res_st_q  <= load_ok ? kwm_pkg::ST_OK : kwm_pkg::ST_DROPPED;
      res_val_q <= '0;
      res_src_q <= '0;
    end
    if (cmd_i.clear_exec) begin
      res_st_q  <= kwm_pkg::ST_OK;
      res_val_q <= '0;
      res_src_q <= '0;
    end
    if (cmd_i.bad_exec) begin
      res_st_q  <= kwm_pkg::ST_DROPPED;
      res_val_q <= '0;
      res_src_q <= '0;
    end
    if (cmd_i.pop_commit) begin
      if (found_q) begin
        res_st_q  <= kwm_pkg::ST_POPPED;
        res_val_q <= bestv_q;
        res_src_q <= best_ext[kwm_pkg::IDX_W-1:0];
      end else begin
        res_st_q  <= kwm_pkg::ST_EMPTY;
        res_val_q <= '0;
        res_src_q <= '0;
      end
    end
    if (cmd_i.out_load) begin
      status_o       <= res_st_q;
      merged_value_o <= res_val_q;
      source_list_o  <= res_src_q;
    end
  end

endmodule

>>> hdl/kway_min_select_merge_top.sv
// Top level of the k-way merge engine.
// Depends on kwm_pkg, kwm_ctrl and kwm_dp (which holds kwm_ram).
//
// Loads append a signed 64-bit value to one of the active lists, pops return
// the smallest head over all active non-empty lists (lowest index on a tie)
// and advance that list, clear empties every list. Each transfer in gives
// exactly one result transfer out. A load, a clear or an unused opcode goes
// through the execute and done states; a pop goes through the execute, scan,
// flush, commit and done states, because the heads of the active lists are
// read through the one read port of the list memory, one list per cycle, and
// compared against the running minimum. A new input is taken while an
// earlier result still waits in the output register.
module kway_min_select_merge_top #(
  parameter int unsigned MAX_LISTS  = 8,
  parameter int unsigned LIST_DEPTH = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [kwm_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [kwm_pkg::OP_W-1:0]             opcode_i,
  input  logic [kwm_pkg::IDX_W-1:0]            list_index_i,
  input  logic signed [kwm_pkg::VAL_W-1:0]     value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [kwm_pkg::ST_W-1:0]             status_o,
  output logic signed [kwm_pkg::VAL_W-1:0]     merged_value_o,
  output logic [kwm_pkg::IDX_W-1:0]            source_list_o
);

  kwm_pkg::cmd_t cmd;
  kwm_pkg::sts_t sts;

  kwm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kwm_dp #(
    .MAX_LISTS  (MAX_LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .opcode_i       (opcode_i),
    .list_index_i   (list_index_i),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (status_o),
    .merged_value_o (merged_value_o),
    .source_list_o  (source_list_o)
  );

endmodule
